// ===== rtl/prms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the page range merge set.
// No dependencies; imported by every module of the block.
package prms_pkg;

  // Field widths fixed by the stream format
  localparam int ModeW     = 1;
  localparam int PfnW      = 52;
  localparam int SizeW     = 32;
  localparam int InDataW   = 88;   // pfn + size, padded to whole bytes
  localparam int InUserW   = 1;    // mode
  localparam int OutDataW  = 8;    // status + hit, padded to a byte

  // Request kinds
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

  // Flags that ride with the scan token from cell to cell
  typedef struct packed {
    logic vld;      // token present in this stage
    logic claimed;  // a free slot has been reserved upstream
    logic hit;      // query overlap found upstream
  } tok_flags_t;

  // Broadcast controls from the controller to every cell
  typedef struct packed {
    logic query;    // current request is a query
    logic commit;   // write merged range into the claimed slot
    logic finish;   // request done, drop all claims
  } ctrl_t;

endpackage

// ===== rtl/prms_cell.sv =====
`timescale 1ns / 1ps
// One table slot of the range set plus one stage of the scan token.
// Depends on prms_pkg.
module prms_cell
  import prms_pkg::*;
#(
  parameter int FRAME_BITS = 52,
  parameter int END_W      = 53
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctl,
  input  logic [FRAME_BITS-1:0] bus_lo,
  input  logic [END_W-1:0]      bus_hi,
  input  tok_flags_t            tok_in,
  input  logic [FRAME_BITS-1:0] tok_lo_in,
  input  logic [END_W-1:0]      tok_hi_in,
  output tok_flags_t            tok_out,
  output logic [FRAME_BITS-1:0] tok_lo_out,
  output logic [END_W-1:0]      tok_hi_out
);

  logic                  valid_r, valid_nxt;
  logic                  claim_r, claim_nxt;
  logic [FRAME_BITS-1:0] start_r, start_nxt;
  logic [END_W-1:0]      end_r, end_nxt;
  tok_flags_t            tok_r, tok_nxt;
  logic [FRAME_BITS-1:0] tok_lo_r, tok_lo_nxt;
  logic [END_W-1:0]      tok_hi_r, tok_hi_nxt;
  logic                  match_add;
  logic                  match_query;

  // Overlap tests against the request range: add also takes touching ranges
  assign match_add   = valid_r && (END_W'(start_r) <= bus_hi) && (end_r >= END_W'(bus_lo));
  assign match_query = valid_r && (END_W'(start_r) < bus_hi) && (end_r > END_W'(bus_lo));

  // Process the token as it passes; apply commit on request finish
  always_comb begin
    valid_nxt  = valid_r;
    claim_nxt  = claim_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    tok_nxt    = tok_in;
    tok_lo_nxt = tok_lo_in;
    tok_hi_nxt = tok_hi_in;
    if (tok_in.vld) begin
      if (ctl.query) begin
        tok_nxt.hit = tok_in.hit | match_query;
      end else begin
        // fold this slot into the running union and free it
        if (match_add) begin
          valid_nxt  = 1'b0;
          tok_lo_nxt = (start_r < tok_lo_in) ? start_r : tok_lo_in;
          tok_hi_nxt = (end_r > tok_hi_in) ? end_r : tok_hi_in;
        end
        // reserve the lowest slot that is free after the fold
        if ((!valid_r || match_add) && !tok_in.claimed) begin
          claim_nxt       = 1'b1;
          tok_nxt.claimed = 1'b1;
        end
      end
    end
    if (ctl.finish) begin
      claim_nxt = 1'b0;
      if (ctl.commit && claim_r) begin
        start_nxt = bus_lo;
        end_nxt   = bus_hi;
        valid_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      claim_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      claim_r <= claim_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    tok_lo_r <= tok_lo_nxt;
    tok_hi_r <= tok_hi_nxt;
  end

  assign tok_out    = tok_r;
  assign tok_lo_out = tok_lo_r;
  assign tok_hi_out = tok_hi_r;

  // A claimed slot is always empty until its commit
  a_claim_empty: assert property (@(posedge clk) disable iff (!rst_n)
    claim_r |-> !valid_r) else $error("claimed slot still holds a range");

  // Commit fills the claimed slot
  a_commit_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && ctl.commit && claim_r |=> valid_r && !claim_r)
    else $error("commit did not fill claimed slot");

  // The scan token is a single pulse
  a_tok_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r.vld |=> !tok_r.vld) else $error("scan token longer than one cycle");

endmodule

// ===== rtl/prms_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer: accepts requests, launches the scan token down the cell
// row, resolves the result and holds it in the output register. Uses prms_pkg.
module prms_ctrl
  import prms_pkg::*;
#(
  parameter int FRAME_BITS = 52,
  parameter int END_W      = 53
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  req_mode,
  input  logic [PfnW-1:0]       req_pfn,
  input  logic [SizeW-1:0]      req_size,
  output ctrl_t                 ctl,
  output logic [FRAME_BITS-1:0] bus_lo,
  output logic [END_W-1:0]      bus_hi,
  output tok_flags_t            tok_first,
  input  tok_flags_t            tok_last,
  input  logic [FRAME_BITS-1:0] tok_last_lo,
  input  logic [END_W-1:0]      tok_last_hi,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_status,
  output logic                  res_hit
);

  state_t                state_r, state_nxt;
  logic                  query_r, query_nxt;
  logic                  empty_r, empty_nxt;
  logic                  full_r, full_nxt;
  logic                  hit_r, hit_nxt;
  logic                  launch_r, launch_nxt;
  logic [FRAME_BITS-1:0] lo_r, lo_nxt;
  logic [END_W-1:0]      hi_r, hi_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic                  res_status_r, res_status_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic [FRAME_BITS-1:0] req_lo;
  logic                  slot_free;

  assign req_lo    = FRAME_BITS'(req_pfn);
  assign slot_free = !res_valid_r || res_ready;

  // Next state and outputs
  always_comb begin
    state_nxt      = state_r;
    query_nxt      = query_r;
    empty_nxt      = empty_r;
    full_nxt       = full_r;
    hit_nxt        = hit_r;
    launch_nxt     = 1'b0;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_valid_nxt  = res_valid_r && !res_ready;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    req_ready      = 1'b0;
    ctl.query      = query_r;
    ctl.commit     = 1'b0;
    ctl.finish     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          query_nxt = (req_mode == MODE_QUERY);
          lo_nxt    = req_lo;
          hi_nxt    = END_W'(req_lo) + END_W'(req_size);
          empty_nxt = (req_size == '0);
          full_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          if (req_size == '0) begin
            state_nxt = ST_RESOLVE;
          end else begin
            launch_nxt = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // capture the union and flags when the token leaves the last cell
        if (tok_last.vld) begin
          lo_nxt    = tok_last_lo;
          hi_nxt    = tok_last_hi;
          hit_nxt   = query_r && tok_last.hit;
          full_nxt  = !query_r && !tok_last.claimed;
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (slot_free) begin
          ctl.finish     = 1'b1;
          ctl.commit     = !query_r && !empty_r && !full_r;
          res_valid_nxt  = 1'b1;
          res_status_nxt = full_r ? STATUS_FULL : STATUS_OK;
          res_hit_nxt    = hit_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    query_r      <= query_nxt;
    empty_r      <= empty_nxt;
    full_r       <= full_nxt;
    hit_r        <= hit_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
  end

  assign bus_lo            = lo_r;
  assign bus_hi            = hi_r;
  assign tok_first.vld     = launch_r;
  assign tok_first.claimed = 1'b0;
  assign tok_first.hit     = 1'b0;
  assign res_valid         = res_valid_r;
  assign res_status        = res_status_r;
  assign res_hit           = res_hit_r;

  // Token is launched only at the start of a scan
  a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> state_r == ST_SCAN) else $error("token launched outside scan");

  // Token leaves the row only while a scan is running
  a_last_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.vld |-> state_r == ST_SCAN) else $error("stray scan token");

  // A query never drops a request as full
  a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && query_r |=> res_valid && res_status == STATUS_OK)
    else $error("query reported table full");

  // A commit never comes with a full status
  a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> ctl.finish && !full_r) else $error("commit on full table");

endmodule

// ===== rtl/page_range_merge_set_top.sv =====
`timescale 1ns / 1ps
// Top level of the page range merge set: controller plus a row of slot cells.
// Depends on prms_pkg, prms_ctrl and prms_cell.
//
// Holds up to ENTRIES disjoint, non-touching half-open page-frame ranges.
// mode 0 adds [pfn, pfn+size): every stored range that overlaps or touches it
// is removed and their union is stored in the lowest free slot; with no free
// slot and nothing merged the add is dropped with status 1. mode 1 reports
// hit when any stored range overlaps [pfn, pfn+size). Size zero stores nothing
// and never hits. Each request gives one result. A request with nonzero size
// launches a scan token that walks the row of slot cells one cell per cycle;
// its result is resolved when the token leaves the last cell, while a size-zero
// request goes straight to resolve. One request is in work at a time; the next
// is taken while the previous result still waits in the output register. Reset
// empties the table at once.
module page_range_merge_set_top
  import prms_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int FRAME_BITS = 52
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [51:0] pfn, [83:52] size, zero pad
  input  logic [InUserW-1:0]  in_tuser,   // [0] mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // [0] status, [1] hit, zero pad
);

  localparam int EndW = ((FRAME_BITS > SizeW) ? FRAME_BITS : SizeW) + 1;

  ctrl_t                 ctl;
  logic [FRAME_BITS-1:0] bus_lo;
  logic [EndW-1:0]       bus_hi;
  tok_flags_t            tok      [ENTRIES+1];
  logic [FRAME_BITS-1:0] tok_lo   [ENTRIES+1];
  logic [EndW-1:0]       tok_hi   [ENTRIES+1];
  logic                  res_status;
  logic                  res_hit;

  prms_ctrl #(
    .FRAME_BITS (FRAME_BITS),
    .END_W      (EndW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_mode    (in_tuser[0]),
    .req_pfn     (in_tdata[PfnW-1:0]),
    .req_size    (in_tdata[PfnW+SizeW-1:PfnW]),
    .ctl         (ctl),
    .bus_lo      (bus_lo),
    .bus_hi      (bus_hi),
    .tok_first   (tok[0]),
    .tok_last    (tok[ENTRIES]),
    .tok_last_lo (tok_lo[ENTRIES]),
    .tok_last_hi (tok_hi[ENTRIES]),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_status  (res_status),
    .res_hit     (res_hit)
  );

  // Token enters the row carrying the request range
  assign tok_lo[0] = bus_lo;
  assign tok_hi[0] = bus_hi;

  // Row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    prms_cell #(
      .FRAME_BITS (FRAME_BITS),
      .END_W      (EndW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .bus_lo     (bus_lo),
      .bus_hi     (bus_hi),
      .tok_in     (tok[i]),
      .tok_lo_in  (tok_lo[i]),
      .tok_hi_in  (tok_hi[i]),
      .tok_out    (tok[i+1]),
      .tok_lo_out (tok_lo[i+1]),
      .tok_hi_out (tok_hi[i+1])
    );
  end

  assign out_tdata = {{(OutDataW-2){1'b0}}, res_hit, res_status};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for page_range_merge_set_top: random add and query requests
// are checked against an interval-set predictor. Depends on prms_pkg and the top.
module tb
  import prms_pkg::*;
();

  localparam int              ENTRIES     = 64;
  localparam int              QUIET_LIMIT = 4000;
  localparam logic [PfnW-1:0] TOP_FRAME   = {PfnW{1'b1}};

  // Predicts the status and hit of each request from its own copy of the table
  class range_set_model;
    typedef struct {
      logic status;
      logic hit;
    } verdict_t;

    logic [PfnW-1:0] lo_frame[ENTRIES];
    logic [PfnW:0]   hi_frame[ENTRIES];
    bit              live[ENTRIES];
    verdict_t        verdicts[$];
    int              errors;

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function int used();
      int n;
      n = 0;
      foreach (live[i]) begin
        if (live[i]) n++;
      end
      return n;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    // Apply one accepted request to the table and queue its result
    function void note_request(logic mode, logic [PfnW-1:0] pfn, logic [SizeW-1:0] size);
      verdict_t      v;
      logic [PfnW:0] lo;
      logic [PfnW:0] hi;
      bit            grown;
      int            slot;
      v.status = STATUS_OK;
      v.hit    = 1'b0;
      lo       = {1'b0, pfn};
      hi       = lo + (PfnW+1)'(size);
      if (size != '0 && mode == MODE_ADD) begin
        // fold every overlapping or touching range until nothing more joins
        grown = 1'b1;
        while (grown) begin
          grown = 1'b0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && {1'b0, lo_frame[i]} <= hi && hi_frame[i] >= lo) begin
              if ({1'b0, lo_frame[i]} < lo) lo = {1'b0, lo_frame[i]};
              if (hi_frame[i] > hi) hi = hi_frame[i];
              live[i] = 1'b0;
              grown   = 1'b1;
            end
          end
        end
        // store in the lowest free slot, or drop the add
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!live[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          v.status = STATUS_FULL;
        end else begin
          lo_frame[slot] = lo[PfnW-1:0];
          hi_frame[slot] = hi;
          live[slot]     = 1'b1;
        end
      end else if (size != '0) begin
        // strict overlap only; touching ranges do not hit
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i] && {1'b0, lo_frame[i]} < hi && hi_frame[i] > lo) v.hit = 1'b1;
        end
      end
      verdicts.push_back(v);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [OutDataW-1:0] data);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("unexpected result: out_tdata %h with no request pending", data);
        errors++;
      end else begin
        v = verdicts.pop_front();
        if (data[0] !== v.status) begin
          $error("status mismatch: expected %0d actual %0d", v.status, data[0]);
          errors++;
        end
        if (data[1] !== v.hit) begin
          $error("hit mismatch: expected %0d actual %0d", v.hit, data[1]);
          errors++;
        end
        if (data[OutDataW-1:2] !== '0) begin
          $error("pad mismatch: expected 0 actual %h", data[OutDataW-1:2]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [InUserW-1:0]  in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  range_set_model      book;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  quiet_cycles  = 0;
  logic [PfnW-1:0]     window_base;

  page_range_merge_set_top #(
    .ENTRIES   (ENTRIES),
    .FRAME_BITS(PfnW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Track both handshakes, stall the result side at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        book.note_request(in_tuser[0], in_tdata[PfnW-1:0], in_tdata[PfnW+SizeW-1:PfnW]);
      end
      if (out_tvalid && out_tready) book.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Stop a hung run
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  // Present one request, idling first at random, and hold it until accepted
  task automatic push_request(input logic mode, input logic [PfnW-1:0] pfn,
                              input logic [SizeW-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(InDataW - PfnW - SizeW){1'b0}}, size, pfn};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off new requests until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
    @(posedge clk);
  endtask

  task automatic pick_window();
    case ($urandom_range(3))
      0: window_base = '0;
      1: window_base = TOP_FRAME - 600;
      default: begin
        window_base = PfnW'({$urandom(), $urandom()});
        if (window_base > TOP_FRAME - 1024) window_base = TOP_FRAME - 1024;
      end
    endcase
  endtask

  // Short ranges inside the current window, so merges and hits are frequent
  task automatic window_request();
    logic [PfnW-1:0]  pfn;
    logic [SizeW-1:0] size;
    int               pick;
    pick = $urandom_range(99);
    pfn  = window_base + PfnW'($urandom_range(511));
    size = SizeW'($urandom_range(24));
    if (pick % 20 == 0) size = '0;
    if (pick < 50) push_request(MODE_ADD, pfn, size);
    else push_request(MODE_QUERY, pfn, size);
  endtask

  // Fully random fields; wide adds only while the table has room
  task automatic noise_request();
    logic [PfnW-1:0]  pfn;
    logic [SizeW-1:0] size;
    logic             mode;
    pfn  = PfnW'({$urandom(), $urandom()});
    size = $urandom();
    if ($urandom_range(1)) size = SizeW'($urandom_range(64));
    mode = MODE_QUERY;
    if ($urandom_range(3) == 0 && book.used() < 40) mode = MODE_ADD;
    push_request(mode, pfn, size);
  endtask

  // Fill the table with isolated ranges, run into the full case, then fold it
  task automatic fill_to_full();
    logic [PfnW-1:0] base;
    base = PfnW'({$urandom(), $urandom()});
    if (base > TOP_FRAME - 4096) base = TOP_FRAME - 4096;
    for (int k = 0; k < 70; k++) begin
      push_request(MODE_ADD, base + PfnW'(3 * k), SizeW'($urandom_range(1, 2)));
    end
    // isolated adds are dropped, a touching add still merges
    for (int k = 0; k < 4; k++) begin
      push_request(MODE_ADD, base + PfnW'(3 * (80 + 2 * k)), 1);
    end
    push_request(MODE_ADD, base + 14, 1);
    push_request(MODE_QUERY, base + 30, 1);
    push_request(MODE_QUERY, base + 32, 1);
    push_request(MODE_QUERY, base + 3 * 80, 1);
    push_request(MODE_ADD, base, 400);
    push_request(MODE_QUERY, base + 399, 1);
  endtask

  task automatic random_phase(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) begin
        if (k != 0) push_request(MODE_ADD, window_base, 1024);
        pick_window();
      end
      if (k == n / 2) begin
        fill_to_full();
        drain();
      end
      if ($urandom_range(99) < 12) noise_request();
      else window_request();
    end
    push_request(MODE_ADD, window_base, 1024);
    drain();
  endtask

  // Edges of the fields, touching and chained merges, empty requests
  task automatic directed();
    push_request(MODE_QUERY, '0, '0);
    push_request(MODE_ADD, 5, '0);
    push_request(MODE_QUERY, '0, '1);
    push_request(MODE_ADD, 100, 10);
    push_request(MODE_ADD, 110, 5);
    push_request(MODE_ADD, 90, 10);
    push_request(MODE_QUERY, 115, 1);
    push_request(MODE_QUERY, 89, 1);
    push_request(MODE_QUERY, 114, 1);
    push_request(MODE_QUERY, 114, '0);
    push_request(MODE_ADD, 200, 5);
    push_request(MODE_ADD, 300, 5);
    push_request(MODE_ADD, 120, 300);
    push_request(MODE_ADD, 115, 5);
    push_request(MODE_QUERY, 419, 1);
    push_request(MODE_QUERY, 420, '1);
    push_request(MODE_ADD, TOP_FRAME, '1);
    push_request(MODE_QUERY, TOP_FRAME, 1);
    push_request(MODE_QUERY, TOP_FRAME - 1, 1);
    push_request(MODE_ADD, '0, 1);
    push_request(MODE_QUERY, '0, '1);
    push_request(MODE_ADD, TOP_FRAME - 32'hFFFF_FFFF, '1);
    push_request(MODE_QUERY, 52'hA_AAAA_AAAA_AAAA, 32'h5555_5555);
  endtask

  initial begin
    book = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 84;
    directed();
    drain();
    random_phase(540);

    send_idle_pct = 84;
    recv_idle_pct = 38;
    random_phase(540);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(540);

    // let any late result show up before judging
    repeat (ENTRIES + 8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
